// ===== sv/psfp_pkg.sv =====
// shared types and constants for the farthest-pair block
// coordinate, point and result formats plus the squared-difference helpers
// no dependencies
package psfp_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DIST_BITS  = 2 * DIFF_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic        [DIST_BITS-1:0]  t_dist;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   point_last;
    } t_point_in;

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_coord first_z;
        t_coord second_x;
        t_coord second_y;
        t_coord second_z;
        t_dist  max_sq_dist;
        logic   found;
        logic   overflow;
    } t_pair_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    localparam int POINT_BITS = $bits(t_point);

    function automatic t_diff coord_diff(input t_coord a, input t_coord b);
        logic [DIFF_BITS-1:0] ea;
        logic [DIFF_BITS-1:0] eb;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        return t_diff'(ea - eb);
    endfunction

    function automatic t_dist diff_sq(input t_diff d);
        logic signed [DIST_BITS-1:0] p;
        p = d * d;
        return t_dist'(p);
    endfunction

endpackage

// ===== sv/psfp_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module psfp_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/point_set_farthest_pair.sv =====
// top level of the farthest-pair block: point store, pair scan sequencer,
// distance pipeline and result register
// depends on psfp_pkg and psfp_ram
//
// Points are taken one per cycle and written to the point memory in arrival
// order; a point that arrives with MAX_POINTS already held is dropped and sets
// the overflow flag. The transfer with point_last set closes the set, and the
// input then stalls while every pair is scanned, one memory read per cycle
// through the single read port of the point memory (one read per first point,
// one per partner), while the distance pipeline drains and while the winning
// points are fetched. The result then waits in an output register and the
// next set may start loading once that register is free. When no pair has a
// nonzero distance found reads 0 and all coordinates read zero.
module point_set_farthest_pair #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pt_valid,
    output logic                 o_pt_stall,
    input  psfp_pkg::t_point_in  i_pt,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output psfp_pkg::t_pair_out  o_res
);

    import psfp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_POINTS);
    localparam logic [AW-1:0] LAST_FULL  = AW'(MAX_POINTS - 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RDI   = 3'd1;
    localparam logic [2:0] S_RDJ   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RDA   = 3'd4;
    localparam logic [2:0] S_RDB   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_last, n_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_point        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_point        ram_rdata;

    logic          pt_xfer;
    logic          res_free;
    logic          pipe_busy;
    logic          iss_valid;
    logic          iss_is_i;
    logic [AW-1:0] iss_idx;
    logic          first_load;
    logic          res_load;
    logic          best_clr;

    logic          r_v1, r_v2, r_v3, r_v4;
    logic          r_s1_is_i;
    logic [AW-1:0] r_s1_idx;
    t_point        r_pi;
    logic [AW-1:0] r_pi_idx;
    logic [AW-1:0] r_ia2, r_ja2, r_ia3, r_ja3, r_ia4, r_ja4;
    t_diff         r_dx, r_dy, r_dz;
    t_dist         r_sqx, r_sqy, r_sqz;
    t_dist         r_sum;
    t_dist         r_best;
    logic [AW-1:0] r_best_i, r_best_j;
    t_point        r_first;
    logic          r_res_valid;
    t_pair_out     r_res;

    psfp_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_pt_stall = (r_state != S_LOAD);
    assign pt_xfer    = i_pt_valid && !o_pt_stall;
    assign res_free   = !r_res_valid || !i_res_stall;
    assign pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;

    assign ram_waddr = r_count[AW-1:0];
    assign ram_wdata = '{x: i_pt.point_x, y: i_pt.point_y, z: i_pt.point_z};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_i        = r_i;
        n_j        = r_j;
        n_last     = r_last;
        ram_we     = 1'b0;
        ram_raddr  = r_i;
        iss_valid  = 1'b0;
        iss_is_i   = 1'b0;
        iss_idx    = r_j;
        first_load = 1'b0;
        res_load   = 1'b0;
        best_clr   = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (pt_xfer) begin
                    if (r_count < COUNT_FULL) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_last  = r_count[AW-1:0];
                    end else begin
                        n_drop = 1'b1;
                        n_last = LAST_FULL;
                    end
                    if (i_pt.point_last) begin
                        n_i = '0;
                        if (r_count == '0) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_state = S_RDI;
                        end
                    end
                end
            end
            S_RDI: begin
                ram_raddr = r_i;
                iss_valid = 1'b1;
                iss_is_i  = 1'b1;
                iss_idx   = r_i;
                n_j       = r_i + AW'(1);
                n_state   = S_RDJ;
            end
            S_RDJ: begin
                ram_raddr = r_j;
                iss_valid = 1'b1;
                iss_idx   = r_j;
                if (r_j == r_last) begin
                    if (r_i == r_last - AW'(1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_RDI;
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                ram_raddr = r_best_i;
                n_state   = S_RDB;
            end
            S_RDB: begin
                ram_raddr  = r_best_j;
                first_load = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                ram_raddr = r_best_j;
                if (res_free) begin
                    res_load = 1'b1;
                    best_clr = 1'b1;
                    n_count  = '0;
                    n_drop   = 1'b0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
            r_last  <= n_last;
        end
    end

    // distance pipeline: read, difference, square, sum, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= iss_valid;
            r_v2 <= r_v1 && !r_s1_is_i;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_s1_is_i <= iss_is_i;
        r_s1_idx  <= iss_idx;
        if (r_v1 && r_s1_is_i) begin
            r_pi     <= ram_rdata;
            r_pi_idx <= r_s1_idx;
        end
        r_dx  <= coord_diff(ram_rdata.x, r_pi.x);
        r_dy  <= coord_diff(ram_rdata.y, r_pi.y);
        r_dz  <= coord_diff(ram_rdata.z, r_pi.z);
        r_ia2 <= r_pi_idx;
        r_ja2 <= r_s1_idx;
        r_sqx <= diff_sq(r_dx);
        r_sqy <= diff_sq(r_dy);
        r_sqz <= diff_sq(r_dz);
        r_ia3 <= r_ia2;
        r_ja3 <= r_ja2;
        r_sum <= r_sqx + r_sqy + r_sqz;
        r_ia4 <= r_ia3;
        r_ja4 <= r_ja3;
    end

    // strict compare keeps the earliest pair on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= '0;
            r_best_i <= '0;
            r_best_j <= '0;
        end else if (best_clr) begin
            r_best   <= '0;
            r_best_i <= '0;
            r_best_j <= '0;
        end else if (r_v4 && (r_sum > r_best)) begin
            r_best   <= r_sum;
            r_best_i <= r_ia4;
            r_best_j <= r_ja4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (first_load) begin
            r_first <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
        if (res_load) begin
            if (r_best != '0) begin
                r_res.first_x  <= r_first.x;
                r_res.first_y  <= r_first.y;
                r_res.first_z  <= r_first.z;
                r_res.second_x <= ram_rdata.x;
                r_res.second_y <= ram_rdata.y;
                r_res.second_z <= ram_rdata.z;
            end else begin
                r_res.first_x  <= '0;
                r_res.first_y  <= '0;
                r_res.first_z  <= '0;
                r_res.second_x <= '0;
                r_res.second_y <= '0;
                r_res.second_z <= '0;
            end
            r_res.max_sq_dist <= r_best;
            r_res.found       <= (r_best != '0);
            r_res.overflow    <= r_drop;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("point count above capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDJ) |-> ((r_j > r_i) && (r_j <= r_last)))
        else $error("partner index out of scan range");

    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best != '0) |-> (r_best_j > r_best_i))
        else $error("best pair indices out of order");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |->
            ((o_res.first_x == '0) && (o_res.second_x == '0) &&
             (o_res.max_sq_dist == '0)))
        else $error("result without pair is not zero");
`endif

endmodule

// ===== dv/psfp_checker.sv =====
// checker for the farthest-pair block: watches both channels, keeps its own copy
// of the point store and predicts the pair each closed set should return
// depends on psfp_pkg
module psfp_checker #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pt_valid,
    input  logic                 i_pt_stall,
    input  psfp_pkg::t_point_in  i_pt,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  psfp_pkg::t_pair_out  i_res,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import psfp_pkg::*;

    t_point      held_pts [MAX_POINTS];
    int unsigned held_count = 0;
    logic        set_dropped = 1'b0;
    t_pair_out   pending_pairs [$];
    int          fail_count = 0;
    int          result_index = 0;

    function automatic t_dist sq_span(input t_point a, input t_point b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        return t_dist'(dx * dx + dy * dy + dz * dz);
    endfunction

    // first pair in load order with the strictly greatest span wins
    function automatic t_pair_out farthest_pair();
        t_pair_out   r;
        t_dist       best;
        t_dist       d;
        int unsigned bi;
        int unsigned bj;
        best = '0;
        bi = 0;
        bj = 0;
        for (int unsigned i = 0; i < held_count; i++) begin
            for (int unsigned j = i; j < held_count; j++) begin
                d = sq_span(held_pts[i], held_pts[j]);
                if (d > best) begin
                    best = d;
                    bi = i;
                    bj = j;
                end
            end
        end
        r = '0;
        if (best != 0) begin
            r.first_x  = held_pts[bi].x;
            r.first_y  = held_pts[bi].y;
            r.first_z  = held_pts[bi].z;
            r.second_x = held_pts[bj].x;
            r.second_y = held_pts[bj].y;
            r.second_z = held_pts[bj].z;
        end
        r.max_sq_dist = best;
        r.found       = (best != 0);
        r.overflow    = set_dropped;
        return r;
    endfunction

    task automatic note_failure(input string what, input longint want_v, input longint got_v);
        fail_count++;
        if (fail_count <= 10) begin
            $display("result %0d %s: expected %0d got %0d", result_index, what, want_v, got_v);
        end
    endtask

    task automatic check_field(input string what, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            note_failure(what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pair_out want;
        if (!i_rst_n) begin
            held_count = 0;
            set_dropped = 1'b0;
            pending_pairs.delete();
        end else begin
            if (i_pt_valid && !i_pt_stall) begin
                if (held_count < MAX_POINTS) begin
                    held_pts[held_count] = '{i_pt.point_x, i_pt.point_y, i_pt.point_z};
                    held_count++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_pt.point_last) begin
                    pending_pairs = {pending_pairs, farthest_pair()};
                    held_count = 0;
                    set_dropped = 1'b0;
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (pending_pairs.size() == 0) begin
                    note_failure("unexpected transfer, found", -1, longint'(i_res.found));
                end else begin
                    want = pending_pairs.pop_front();
                    check_field("first_x", longint'(want.first_x), longint'(i_res.first_x));
                    check_field("first_y", longint'(want.first_y), longint'(i_res.first_y));
                    check_field("first_z", longint'(want.first_z), longint'(i_res.first_z));
                    check_field("second_x", longint'(want.second_x),
                                longint'(i_res.second_x));
                    check_field("second_y", longint'(want.second_y),
                                longint'(i_res.second_y));
                    check_field("second_z", longint'(want.second_z),
                                longint'(i_res.second_z));
                    check_field("max_sq_dist", longint'(want.max_sq_dist),
                                longint'(i_res.max_sq_dist));
                    check_field("found", longint'(want.found), longint'(i_res.found));
                    check_field("overflow", longint'(want.overflow), longint'(i_res.overflow));
                end
                result_index++;
            end
        end
        o_pending <= pending_pairs.size();
        o_errors  <= fail_count;
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the farthest-pair block: clock, reset, point sets and
// random idling on both channels, with the verdict taken from psfp_checker
// depends on psfp_pkg, point_set_farthest_pair and psfp_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psfp_pkg::*;

    localparam int     MAX_POINTS      = 1024;
    localparam int     RANDOM_ITEMS    = 720;
    localparam int     HOLD_CYCLES     = 3000;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     WATCHDOG_CYCLES = 2000000;
    localparam t_coord COORD_MAX       = t_coord'((1 << (COORD_BITS - 1)) - 1);
    localparam t_coord COORD_MIN       = t_coord'(-(1 << (COORD_BITS - 1)));

    typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE, SPREAD_MIXED} t_spread;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      pt_valid = 1'b0;
    logic      pt_stall;
    t_point_in pt_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    t_pair_out res_data;
    int        errors;
    int        pending;
    int        items_sent = 0;
    int        idle_cycles = 0;
    bit        burst = 1'b0;
    bit        hold_req = 1'b0;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    point_set_farthest_pair #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pt_valid  (pt_valid),
        .o_pt_stall  (pt_stall),
        .i_pt        (pt_data),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res_data)
    );

    psfp_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pt_valid  (pt_valid),
        .i_pt_stall  (pt_stall),
        .i_pt        (pt_data),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_res       (res_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic t_coord rand_coord(input t_spread spread);
        int v;
        case (spread)
            SPREAD_FULL: begin
                return t_coord'($urandom());
            end
            SPREAD_NEAR: begin
                v = $urandom_range(0, 4);
                return t_coord'(v - 2);
            end
            SPREAD_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return t_coord'(-1);
                    3: return t_coord'(1);
                    default: return '0;
                endcase
            end
            default: begin
                return rand_coord(t_spread'($urandom_range(0, 2)));
            end
        endcase
    endfunction

    task automatic send_point(input t_coord x, input t_coord y, input t_coord z,
                              input logic last);
        int gap;
        pt_valid <= 1'b1;
        pt_data  <= '{x, y, z, last};
        @(posedge clk);
        while (pt_stall) @(posedge clk);
        items_sent++;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_set(input int n, input t_spread spread);
        for (int i = 0; i < n; i++) begin
            send_point(rand_coord(spread), rand_coord(spread), rand_coord(spread), i == n - 1);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int free;
        int busy;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                free = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 8);
                busy = idle_len();
                res_stall <= 1'b0;
                repeat (free) @(posedge clk);
                if (busy > 0) begin
                    res_stall <= 1'b1;
                    repeat (busy) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pt_valid && !pt_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[point_set_farthest_pair] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int random_end;
        int n;
        int r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point, then the widest possible pair
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // coincident points
        repeat (2) send_point(COORD_MIN, '0, COORD_MAX, 1'b0);
        send_point(COORD_MIN, '0, COORD_MAX, 1'b1);
        // tie between diagonals of a unit square, earlier pair wins
        send_point(t_coord'(0), t_coord'(0), t_coord'(0), 1'b0);
        send_point(t_coord'(1), t_coord'(1), t_coord'(0), 1'b0);
        send_point(t_coord'(1), t_coord'(0), t_coord'(0), 1'b0);
        send_point(t_coord'(0), t_coord'(1), t_coord'(0), 1'b1);
        send_point('0, '0, '0, 1'b1);
        send_point(COORD_MAX, COORD_MIN, '0, 1'b0);
        send_point(COORD_MIN, COORD_MAX, t_coord'(-1), 1'b1);

        hold_req = 1'b1;
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            r = $urandom_range(0, 99);
            if (r < 70) n = $urandom_range(1, 8);
            else if (r < 96) n = $urandom_range(9, 40);
            else n = $urandom_range(60, 160);
            burst = ($urandom_range(0, 3) == 0);
            send_set(n, t_spread'($urandom_range(0, 3)));
        end
        burst = 1'b0;
        pt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("[point_set_farthest_pair] OK");
        end else begin
            $display("[point_set_farthest_pair] ERROR");
        end
        $finish;
    end

endmodule
